FILE: rtl/drc_pkg.sv
// digital rain cell engine: shared constants, types and lookup functions
// used by the interfaces, the serial divider, the cell store and the top level
// no dependencies
package drc_pkg;

  // geometry
  localparam int NUM_COLS    = 22;
  localparam int NUM_ROWS    = 12;
  localparam int CELL_COUNT  = NUM_COLS * NUM_ROWS;
  localparam int GLYPH_COUNT = 150;
  localparam int GLYPH_LOW   = 94;

  // field widths
  localparam int COL_W   = 5;
  localparam int ROW_W   = 4;
  localparam int DT_W    = 16;
  localparam int RAND_W  = 32;
  localparam int ALPHA_W = 8;
  localparam int GLYPH_W = 8;
  localparam int CODE_W  = 16;
  localparam int COLOR_W = 16;
  localparam int ADDR_W  = $clog2(CELL_COUNT);

  // column state widths: 16.8 head position keeps only the bits that reach a row
  localparam int POS_W   = 24;
  localparam int HROW_W  = 16;
  localparam int TRAIL_W = 4;
  localparam int PER_W   = 2;

  // serial divider sizing
  localparam int DIV_W = 32;
  localparam int DVS_W = 9;
  localparam int CNT_W = 6;

  // elapsed time clamp
  localparam int DT_LIMIT = 100;
  localparam int DTC_W    = 7;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  localparam logic [CODE_W-1:0]  CODE_BASE      = 16'h0021;
  localparam logic [CODE_W-1:0]  CODE_HIGH_BASE = 16'hFF66;
  localparam logic [COLOR_W-1:0] HEAD_COLOR     = 16'hFFFF;
  localparam logic [COLOR_W-1:0] DIGIT_COLOR    = 16'hFEA0;
  localparam logic [COLOR_W-1:0] TAIL_COLOR     = 16'h07E0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPEED   = 2'd0,
    CFG_DENSITY = 2'd1,
    CFG_FLOOR   = 2'd2,
    CFG_ROWS    = 2'd3
  } cfg_idx_t;

  // divider request and status
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_stat_t;

  // one stored cell: glyph and last alpha
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [ALPHA_W-1:0] alpha;
  } cell_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    cell_word_t        data;
  } cell_wr_t;

  // respawn gap per density
  function automatic logic [5:0] gap_of(input logic [1:0] d);
    case (d)
      2'd0:    gap_of = 6'd4;
      2'd1:    gap_of = 6'd9;
      2'd2:    gap_of = 6'd15;
      default: gap_of = 6'd22;
    endcase
  endfunction

  // minimum trail per density
  function automatic logic [TRAIL_W-1:0] tmin_of(input logic [1:0] d);
    case (d)
      2'd0:    tmin_of = 4'd7;
      2'd1:    tmin_of = 4'd5;
      2'd2:    tmin_of = 4'd4;
      default: tmin_of = 4'd3;
    endcase
  endfunction

  // trail span per density
  function automatic logic [2:0] tspan_of(input logic [1:0] d);
    case (d)
      2'd0:    tspan_of = 3'd6;
      2'd1:    tspan_of = 3'd5;
      2'd2:    tspan_of = 3'd4;
      default: tspan_of = 3'd3;
    endcase
  endfunction

  // digit floor alpha, selects above the table saturate to full
  function automatic logic [ALPHA_W-1:0] floor_of(input logic [2:0] sel);
    case (sel)
      3'd0:    floor_of = 8'd191;
      3'd1:    floor_of = 8'd128;
      3'd2:    floor_of = 8'd158;
      3'd3:    floor_of = 8'd224;
      default: floor_of = 8'd255;
    endcase
  endfunction

  // glyph index to character code
  function automatic logic [CODE_W-1:0] code_of(input logic [GLYPH_W-1:0] g);
    if (g < GLYPH_W'(GLYPH_LOW)) begin
      code_of = CODE_BASE + CODE_W'(g);
    end else begin
      code_of = CODE_HIGH_BASE + CODE_W'(g) - CODE_W'(GLYPH_LOW);
    end
  endfunction

endpackage

FILE: rtl/drc_if.sv
// digital rain cell engine: valid/ready channel interfaces for cell items
// and render results
// depends on drc_pkg
interface drc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [drc_pkg::COL_W-1:0]     column;
  logic [drc_pkg::ROW_W-1:0]     row;
  logic [drc_pkg::DT_W-1:0]      elapsed_ms;
  logic [drc_pkg::RAND_W-1:0]    rand_head;
  logic [drc_pkg::RAND_W-1:0]    rand_trail;
  logic [drc_pkg::RAND_W-1:0]    rand_period;
  logic [drc_pkg::RAND_W-1:0]    rand_glyph;
  logic                          clock_digit;

  modport source (
    output valid, req_type, column, row, elapsed_ms, rand_head, rand_trail,
           rand_period, rand_glyph, clock_digit,
    input  ready
  );
  modport sink (
    input  valid, req_type, column, row, elapsed_ms, rand_head, rand_trail,
           rand_period, rand_glyph, clock_digit,
    output ready
  );
endinterface

interface drc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          draw;
  logic [drc_pkg::ALPHA_W-1:0]   alpha;
  logic [drc_pkg::GLYPH_W-1:0]   glyph_index;
  logic [drc_pkg::CODE_W-1:0]    code_point;
  logic [drc_pkg::COLOR_W-1:0]   color;

  modport source (
    output valid, draw, alpha, glyph_index, code_point, color,
    input  ready
  );
  modport sink (
    input  valid, draw, alpha, glyph_index, code_point, color,
    output ready
  );
endinterface

FILE: rtl/drc_div.sv
// digital rain cell engine: bit-serial restoring divider, one quotient bit
// per cycle over a left-aligned dividend of nbits bits
// depends on drc_pkg
module drc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  drc_pkg::div_req_t  req,
  output drc_pkg::div_stat_t stat
);

  logic [drc_pkg::DIV_W-1:0] q_r, q_nxt;
  logic [drc_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [drc_pkg::DVS_W-1:0] div_r;
  logic [drc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [drc_pkg::DVS_W:0]   trial;
  logic [drc_pkg::DVS_W:0]   diff;
  logic                      ge;

  // one trial subtraction per cycle
  assign trial = {rem_r, q_r[drc_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      cnt_nxt  = req.nbits;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt    = {q_r[drc_pkg::DIV_W-2:0], ge};
      rem_nxt  = ge ? diff[drc_pkg::DVS_W-1:0] : trial[drc_pkg::DVS_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != drc_pkg::CNT_W'(1);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      div_r <= req.divisor;
    end
  end

  assign stat.busy = busy_r;
  assign stat.quot = q_r;
  assign stat.rem  = rem_r;

  // checks
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with zero step count");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> rem_r < div_r)
    else $error("divider remainder not below divisor");

endmodule

FILE: rtl/drc_cell_store.sv
// digital rain cell engine: per-cell store of glyph and last alpha, one write
// port, one registered read port, clearing pass after reset
// depends on drc_pkg
module drc_cell_store (
  input  logic                        clk,
  input  logic                        rst_n,
  input  drc_pkg::cell_wr_t           wr,
  input  logic [drc_pkg::ADDR_W-1:0]  rd_addr,
  output drc_pkg::cell_word_t         rd_data,
  output logic                        clearing
);

  drc_pkg::cell_word_t       mem [drc_pkg::CELL_COUNT];
  drc_pkg::cell_word_t       rd_data_r;
  logic [drc_pkg::ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic                      clearing_r, clearing_nxt;
  logic                      clr_last;

  // clearing sweep, one entry per cycle
  assign clr_last = clr_addr_r == drc_pkg::ADDR_W'(drc_pkg::CELL_COUNT - 1);

  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_last) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data  = rd_data_r;
  assign clearing = clearing_r;

  // checks
  a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !wr.we)
    else $error("cell write during clearing pass");

  a_clr_range: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> clr_addr_r < drc_pkg::ADDR_W'(drc_pkg::CELL_COUNT))
    else $error("clearing address beyond store");

  a_clr_full: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clearing_r) |-> $past(clr_last))
    else $error("clearing pass ended early");

endmodule

FILE: rtl/digital_rain_cell_engine.sv
// digital rain cell engine top level: item control, column state, config
// registers and result register
// depends on drc_pkg, drc_if, drc_div, drc_cell_store
//
//   channel   direction  handshake      payload
//   in_ch     in         valid/ready    req_type column row elapsed_ms rand_* clock_digit
//   out_ch    out        valid/ready    draw alpha glyph_index code_point color
//   cfg_*     in         cfg_we only    cfg_index cfg_data
//
// one item at a time: the input transfer starts the dividers, then the head, respawn,
// distance and final steps follow, the step divider rerun for the fading alpha unless
// the item is a seed, a dark or a head cell; the 32-bit bit-serial modulo of the
// random words beside the step division (five dividers side by side) takes most of the time.
// after reset a clearing pass over all 264 cells of the cell store holds in_ch.ready low.
// a result waits in the output register while the next item is taken; an item
// finishing while that register is still full waits for out_ch.ready.
module digital_rain_cell_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  drc_in_if.sink                          in_ch,
  drc_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [drc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [drc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_HEAD  = 6'b000100,
    ST_RESP  = 6'b001000,
    ST_KCALC = 6'b010000,
    ST_FINAL = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [1:0] speed_r;
  logic [1:0] density_r;
  logic [2:0] floor_sel_r;
  logic [3:0] vis_rows_r;

  // column state
  logic [drc_pkg::POS_W-1:0]   head_pos_r [drc_pkg::NUM_COLS];
  logic [drc_pkg::TRAIL_W-1:0] trail_r    [drc_pkg::NUM_COLS];
  logic [drc_pkg::PER_W-1:0]   period_r   [drc_pkg::NUM_COLS];

  // item registers
  logic                        seed_r;
  logic [drc_pkg::COL_W-1:0]   col_r;
  logic [drc_pkg::ROW_W-1:0]   row_r;
  logic                        digit_r;
  logic                        in_range_r;
  logic [drc_pkg::ADDR_W-1:0]  addr_r;
  logic                        k_zero_r;
  logic                        k_in_r;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic                        draw_r;
  logic [drc_pkg::ALPHA_W-1:0] alpha_r;
  logic [drc_pkg::GLYPH_W-1:0] glyph_r;
  logic [drc_pkg::CODE_W-1:0]  code_r;
  logic [drc_pkg::COLOR_W-1:0] color_r;

  logic accept;
  logic clearing;
  logic in_col_ok;
  logic in_row_ok;
  logic [drc_pkg::PER_W-1:0]  per_in;
  logic [drc_pkg::PER_W-1:0]  per_eff;
  logic [drc_pkg::DTC_W-1:0]  dt_cl;
  logic [5:0]                 span;

  drc_pkg::div_req_t  step_req, head_req, trail_req, per_req, glyph_req;
  drc_pkg::div_stat_t step_st, head_st, trail_st, per_st, glyph_st;
  drc_pkg::cell_wr_t   cell_wr;
  drc_pkg::cell_word_t cell_rd;

  logic                        row0;
  logic                        upd_head;
  logic [drc_pkg::HROW_W-1:0]  cur_hrow;
  logic [drc_pkg::TRAIL_W-1:0] cur_trail;
  logic [3:0]                  rows_sat;
  logic [17:0]                 tail_row;
  logic                        respawn;
  logic                        do_place;
  logic [drc_pkg::POS_W-1:0]   place_pos;
  logic [16:0]                 k;
  logic                        k_zero;
  logic                        k_in;
  logic                        alpha_go;
  logic [drc_pkg::TRAIL_W-1:0] fade_x;
  logic [11:0]                 fade_x255;
  logic                        divs_busy;
  logic                        final_go;
  logic [drc_pkg::ALPHA_W-1:0] a_base;
  logic [drc_pkg::ALPHA_W-1:0] a_fl;
  logic [drc_pkg::ALPHA_W-1:0] a_val;
  logic [drc_pkg::GLYPH_W-1:0] g_new;
  logic [drc_pkg::GLYPH_W-1:0] g_out;
  logic                        changed;
  logic                        draw;

  // input handshake
  assign in_ch.ready = (state_r == ST_IDLE) && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r     <= '0;
      density_r   <= '0;
      floor_sel_r <= '0;
      vis_rows_r  <= 4'(drc_pkg::NUM_ROWS);
    end else if (cfg_we) begin
      case (drc_pkg::cfg_idx_t'(cfg_index))
        drc_pkg::CFG_SPEED:   speed_r     <= cfg_data[1:0];
        drc_pkg::CFG_DENSITY: density_r   <= cfg_data[1:0];
        drc_pkg::CFG_FLOOR:   floor_sel_r <= cfg_data[2:0];
        drc_pkg::CFG_ROWS:    vis_rows_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // operands taken at the input transfer, period only read for an in-grid render
  assign in_col_ok = in_ch.column < drc_pkg::COL_W'(drc_pkg::NUM_COLS);
  assign in_row_ok = in_ch.row < drc_pkg::ROW_W'(drc_pkg::NUM_ROWS);
  assign per_in    = (in_col_ok && in_row_ok && in_ch.req_type) ? period_r[in_ch.column] : '0;
  assign per_eff   = (per_in == '0) ? drc_pkg::PER_W'(1) : per_in;

  always_comb begin
    if (in_ch.elapsed_ms > drc_pkg::DT_W'(drc_pkg::DT_LIMIT)) begin
      dt_cl = drc_pkg::DTC_W'(drc_pkg::DT_LIMIT);
    end else if (in_ch.elapsed_ms == '0) begin
      dt_cl = drc_pkg::DTC_W'(1);
    end else begin
      dt_cl = in_ch.elapsed_ms[drc_pkg::DTC_W-1:0];
    end
  end

  // seed spawns above the whole display, respawn only by the gap
  assign span = in_ch.req_type ? drc_pkg::gap_of(density_r)
                               : 6'(drc_pkg::NUM_ROWS) + drc_pkg::gap_of(density_r);

  // divider requests: the step divider is reused for the fading alpha
  always_comb begin
    step_req.start = accept || alpha_go;
    if (accept) begin
      step_req.dividend = {1'b0, dt_cl, 8'd0, 16'd0};
      step_req.divisor  = drc_pkg::DVS_W'({per_eff, 4'd0}) << speed_r;
      step_req.nbits    = drc_pkg::CNT_W'(16);
    end else begin
      step_req.dividend = {fade_x255, 20'd0};
      step_req.divisor  = drc_pkg::DVS_W'(cur_trail);
      step_req.nbits    = drc_pkg::CNT_W'(12);
    end

    head_req.start     = accept;
    head_req.dividend  = in_ch.rand_head;
    head_req.divisor   = drc_pkg::DVS_W'(span);
    head_req.nbits     = drc_pkg::CNT_W'(drc_pkg::DIV_W);

    trail_req.start    = accept;
    trail_req.dividend = in_ch.rand_trail;
    trail_req.divisor  = drc_pkg::DVS_W'(drc_pkg::tspan_of(density_r));
    trail_req.nbits    = drc_pkg::CNT_W'(drc_pkg::DIV_W);

    per_req.start      = accept;
    per_req.dividend   = in_ch.rand_period;
    per_req.divisor    = drc_pkg::DVS_W'(3);
    per_req.nbits      = drc_pkg::CNT_W'(drc_pkg::DIV_W);

    glyph_req.start    = accept;
    glyph_req.dividend = in_ch.rand_glyph;
    glyph_req.divisor  = drc_pkg::DVS_W'(drc_pkg::GLYPH_COUNT);
    glyph_req.nbits    = drc_pkg::CNT_W'(drc_pkg::DIV_W);
  end

  drc_div u_div_step  (.clk(clk), .rst_n(rst_n), .req(step_req),  .stat(step_st));
  drc_div u_div_head  (.clk(clk), .rst_n(rst_n), .req(head_req),  .stat(head_st));
  drc_div u_div_trail (.clk(clk), .rst_n(rst_n), .req(trail_req), .stat(trail_st));
  drc_div u_div_per   (.clk(clk), .rst_n(rst_n), .req(per_req),   .stat(per_st));
  drc_div u_div_glyph (.clk(clk), .rst_n(rst_n), .req(glyph_req), .stat(glyph_st));

  assign divs_busy = step_st.busy || head_st.busy || trail_st.busy ||
                     per_st.busy || glyph_st.busy;

  // item registers
  always_ff @(posedge clk) begin
    if (accept) begin
      seed_r     <= !in_ch.req_type;
      col_r      <= in_ch.column;
      row_r      <= in_ch.row;
      digit_r    <= in_ch.clock_digit;
      in_range_r <= in_col_ok && in_row_ok;
      addr_r     <= drc_pkg::ADDR_W'(in_ch.column) * drc_pkg::ADDR_W'(drc_pkg::NUM_ROWS)
                    + drc_pkg::ADDR_W'(in_ch.row);
    end
    if (state_r == ST_KCALC) begin
      k_zero_r <= k_zero;
      k_in_r   <= k_in;
    end
  end

  // column head advance and respawn
  assign row0      = row_r == '0;
  assign upd_head  = (state_r == ST_HEAD) && in_range_r && !seed_r && row0;
  assign cur_hrow  = head_pos_r[col_r][drc_pkg::POS_W-1:8];
  assign cur_trail = trail_r[col_r];
  assign rows_sat  = (vis_rows_r > 4'(drc_pkg::NUM_ROWS)) ? 4'(drc_pkg::NUM_ROWS) : vis_rows_r;
  assign tail_row  = {{2{cur_hrow[drc_pkg::HROW_W-1]}}, cur_hrow} - 18'(cur_trail);
  assign respawn   = $signed(tail_row) > $signed({14'd0, rows_sat});
  assign do_place  = (state_r == ST_RESP) && in_range_r && row0 && (seed_r || respawn);
  assign place_pos = {(16'd0 - 16'(head_st.rem[5:0])), 8'd0};

  always_ff @(posedge clk) begin
    if (upd_head) begin
      head_pos_r[col_r] <= head_pos_r[col_r] + drc_pkg::POS_W'(step_st.quot[15:0]);
    end else if (do_place) begin
      head_pos_r[col_r] <= place_pos;
      trail_r[col_r]    <= drc_pkg::tmin_of(density_r) + drc_pkg::TRAIL_W'(trail_st.rem[2:0]);
      period_r[col_r]   <= drc_pkg::PER_W'(1) + per_st.rem[1:0];
    end
  end

  // distance of the cell behind the head
  assign k         = {cur_hrow[drc_pkg::HROW_W-1], cur_hrow} - 17'(row_r);
  assign k_zero    = k == '0;
  assign k_in      = !k[16] && !k_zero && (k <= 17'(cur_trail));
  assign fade_x    = cur_trail - k[drc_pkg::TRAIL_W-1:0];
  assign fade_x255 = {fade_x, 8'd0} - 12'(fade_x);
  assign alpha_go  = (state_r == ST_KCALC) && in_range_r && !seed_r && k_in;

  // final alpha, glyph re-roll and result
  assign final_go = (state_r == ST_FINAL) && !step_st.busy && (!out_valid_r || out_ch.ready);
  assign a_base   = k_zero_r ? 8'd255 : (k_in_r ? step_st.quot[7:0] : 8'd0);
  assign a_fl     = drc_pkg::floor_of(floor_sel_r);
  assign a_val    = (digit_r && (a_base < a_fl)) ? a_fl : a_base;
  assign g_new    = glyph_st.rem[drc_pkg::GLYPH_W-1:0];
  assign changed  = a_val != cell_rd.alpha;
  assign g_out    = (changed && (a_val != '0)) ? g_new : cell_rd.glyph;
  assign draw     = in_range_r && !seed_r && (a_val != '0);

  always_comb begin
    cell_wr.we   = final_go && in_range_r && (seed_r || changed);
    cell_wr.addr = addr_r;
    if (seed_r) begin
      cell_wr.data.glyph = g_new;
      cell_wr.data.alpha = '0;
    end else begin
      cell_wr.data.glyph = g_out;
      cell_wr.data.alpha = a_val;
    end
  end

  drc_cell_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (cell_wr),
    .rd_addr  (addr_r),
    .rd_data  (cell_rd),
    .clearing (clearing)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_DIV;
      ST_DIV:   if (!divs_busy) state_nxt = ST_HEAD;
      ST_HEAD:  state_nxt = ST_RESP;
      ST_RESP:  state_nxt = ST_KCALC;
      ST_KCALC: state_nxt = ST_FINAL;
      ST_FINAL: if (final_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // output register, freed by the result transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (final_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (final_go) begin
      draw_r <= draw;
      if (draw) begin
        alpha_r <= a_val;
        glyph_r <= g_out;
        code_r  <= drc_pkg::code_of(g_out);
        if (k_zero_r) begin
          color_r <= drc_pkg::HEAD_COLOR;
        end else if (digit_r) begin
          color_r <= drc_pkg::DIGIT_COLOR;
        end else begin
          color_r <= drc_pkg::TAIL_COLOR;
        end
      end else begin
        alpha_r <= '0;
        glyph_r <= '0;
        code_r  <= '0;
        color_r <= '0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.draw        = draw_r;
  assign out_ch.alpha       = alpha_r;
  assign out_ch.glyph_index = glyph_r;
  assign out_ch.code_point  = code_r;
  assign out_ch.color       = color_r;

  // checks
  a_dark_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !draw_r) |->
      (alpha_r == '0) && (glyph_r == '0) && (code_r == '0) && (color_r == '0))
    else $error("dark result carries nonzero payload");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINAL))
    else $error("result loaded outside final step");

  a_cell_write: assert property (@(posedge clk) disable iff (!rst_n)
    cell_wr.we |-> (state_r == ST_FINAL) && in_range_r)
    else $error("cell store written outside final step");

endmodule

FILE: sim/tb_top.sv
// testbench for the digital rain cell engine: seeds and renders cells over valid/ready
// channels, predicts every result in place and compares it field by field
// depends on drc_pkg, drc_if and digital_rain_cell_engine
`timescale 1ns / 1ps

module tb_top;
  import drc_pkg::*;

  localparam bit REQ_SEED      = 1'b0;
  localparam bit REQ_RENDER    = 1'b1;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PRINT_LIMIT   = 20;

  typedef struct packed {
    bit                req_type;
    bit [COL_W-1:0]    column;
    bit [ROW_W-1:0]    row;
    bit [DT_W-1:0]     elapsed_ms;
    bit [RAND_W-1:0]   rand_head;
    bit [RAND_W-1:0]   rand_trail;
    bit [RAND_W-1:0]   rand_period;
    bit [RAND_W-1:0]   rand_glyph;
    bit                clock_digit;
  } cell_req_t;

  typedef struct packed {
    bit                draw;
    bit [ALPHA_W-1:0]  alpha;
    bit [GLYPH_W-1:0]  glyph_index;
    bit [CODE_W-1:0]   code_point;
    bit [COLOR_W-1:0]  color;
  } cell_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drc_in_if  in_ch ();
  drc_out_if out_ch ();

  digital_rain_cell_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted register settings
  bit [1:0] speed_sel;
  bit [1:0] dens_sel;
  bit [2:0] floor_sel;
  bit [3:0] rows_sel = 4'd12;

  // predicted column and cell state
  bit [31:0]   col_pos    [NUM_COLS];
  int          col_row    [NUM_COLS];
  int unsigned col_trail  [NUM_COLS];
  int unsigned col_period [NUM_COLS];
  bit          col_seeded [NUM_COLS];
  bit [7:0]    glyph_mem  [CELL_COUNT];
  bit [7:0]    last_alpha [CELL_COUNT];

  cell_res_t expected_cells[$];

  int burst_left;
  int rx_open_left;
  int rx_stall_left;
  int accepted_cells;
  int transfers_in;
  int results_seen;
  int drawn_cells;
  int respawns;
  int settings_loaded;
  int mismatch_count;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(10_000_000);
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
               results_seen, what, got, want);
    end
  endtask

  // respawn gap in rows per density
  function automatic int unsigned gap_rows(input bit [1:0] d);
    case (d)
      2'd0:    return 4;
      2'd1:    return 9;
      2'd2:    return 15;
      default: return 22;
    endcase
  endfunction

  // new head above the display, new trail and fall period
  function automatic void respawn_column(input int col, input int unsigned span,
                                         input cell_req_t item);
    bit [31:0] off;
    int unsigned tmin;
    int unsigned tspan;
    case (dens_sel)
      2'd0:    begin tmin = 7; tspan = 6; end
      2'd1:    begin tmin = 5; tspan = 5; end
      2'd2:    begin tmin = 4; tspan = 4; end
      default: begin tmin = 3; tspan = 3; end
    endcase
    off = item.rand_head % span;
    col_pos[col]    = (32'd0 - off) << 8;
    col_row[col]    = -int'(off);
    col_trail[col]  = tmin + (item.rand_trail % tspan);
    col_period[col] = 1 + (item.rand_period % 32'd3);
  endfunction

  // expected result of one accepted item, updating the predicted state
  function automatic cell_res_t rain_cell_result(input cell_req_t item);
    cell_res_t res;
    int        c;
    int        cidx;
    int        head_gap;
    int        trail;
    bit [31:0] dt;
    bit [31:0] per;
    bit [31:0] vis;
    bit [7:0]  shade;
    bit [7:0]  fl;
    res = '0;
    if (item.column >= NUM_COLS || item.row >= NUM_ROWS) return res;
    c    = item.column;
    cidx = c * NUM_ROWS + item.row;

    // seed: new glyph, forget alpha, top row also places the head
    if (item.req_type == REQ_SEED) begin
      glyph_mem[cidx]  = 8'(item.rand_glyph % GLYPH_COUNT);
      last_alpha[cidx] = 8'd0;
      if (item.row == 0) respawn_column(c, NUM_ROWS + gap_rows(dens_sel), item);
      return res;
    end

    // top row advances the head and respawns once the trail has left
    if (item.row == 0) begin
      per = (col_period[c] == 0) ? 32'd1 : col_period[c];
      dt  = (item.elapsed_ms > DT_LIMIT) ? 32'd100 : 32'(item.elapsed_ms);
      if (dt == 0) dt = 32'd1;
      col_pos[c] += (dt << 8) / (per * (32'd16 << speed_sel));
      col_row[c]  = int'($signed(col_pos[c][23:8]));
      vis = (rows_sel > NUM_ROWS) ? NUM_ROWS : rows_sel;
      if (col_row[c] - int'(col_trail[c]) > int'(vis)) begin
        respawn_column(c, gap_rows(dens_sel), item);
        respawns++;
      end
    end

    // fading alpha along the trail
    trail    = col_trail[c];
    head_gap = col_row[c] - int'(item.row);
    shade    = 8'd0;
    if (head_gap == 0) begin
      shade = 8'd255;
    end else if (head_gap > 0 && head_gap <= trail) begin
      shade = 8'(((trail - head_gap) * 255) / trail);
    end

    // clock digit floor
    case (floor_sel)
      3'd0:    fl = 8'd191;
      3'd1:    fl = 8'd128;
      3'd2:    fl = 8'd158;
      3'd3:    fl = 8'd224;
      default: fl = 8'd255;
    endcase
    if (item.clock_digit && shade < fl) shade = fl;

    // glyph re-roll on a change to a lit alpha
    if (shade != last_alpha[cidx]) begin
      last_alpha[cidx] = shade;
      if (shade != 0) glyph_mem[cidx] = 8'(item.rand_glyph % GLYPH_COUNT);
    end
    if (shade == 0) return res;

    drawn_cells++;
    res.draw        = 1'b1;
    res.alpha       = shade;
    res.glyph_index = glyph_mem[cidx];
    res.code_point  = (glyph_mem[cidx] < GLYPH_LOW) ?
                      CODE_BASE + 16'(glyph_mem[cidx]) :
                      CODE_HIGH_BASE + 16'(glyph_mem[cidx]) - 16'(GLYPH_LOW);
    res.color       = (head_gap == 0) ? HEAD_COLOR :
                      (item.clock_digit ? DIGIT_COLOR : TAIL_COLOR);
    return res;
  endfunction

  // elapsed time mix: mostly small steps, some zero, clamped and wide values
  function automatic bit [DT_W-1:0] pick_elapsed();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'($urandom_range(101, 65535));
      2:       return 16'($urandom);
      3:       return 16'd100;
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic cell_req_t make_cell(input bit kind, input int col, input int row);
    cell_req_t item;
    item.req_type    = kind;
    item.column      = 5'(col);
    item.row         = 4'(row);
    item.elapsed_ms  = pick_elapsed();
    item.rand_head   = $urandom;
    item.rand_trail  = $urandom;
    item.rand_period = $urandom;
    item.rand_glyph  = $urandom;
    item.clock_digit = ($urandom_range(0, 3) == 0);
    return item;
  endfunction

  function automatic int pick_seeded_column();
    int col;
    do col = $urandom_range(0, NUM_COLS - 1); while (!col_seeded[col]);
    return col;
  endfunction

  // one input transfer, sent in bursts with random gaps in between
  task automatic send_cell(input cell_req_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= item.req_type;
    in_ch.column      <= item.column;
    in_ch.row         <= item.row;
    in_ch.elapsed_ms  <= item.elapsed_ms;
    in_ch.rand_head   <= item.rand_head;
    in_ch.rand_trail  <= item.rand_trail;
    in_ch.rand_period <= item.rand_period;
    in_ch.rand_glyph  <= item.rand_glyph;
    in_ch.clock_digit <= item.clock_digit;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_cells.push_back(rain_cell_result(item));
    transfers_in++;
    if (item.column < NUM_COLS && item.row < NUM_ROWS) accepted_cells++;
  endtask

  // stop sending and let every pending result come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input bit [1:0] spd, input bit [1:0] dens,
                             input bit [2:0] flr, input bit [3:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPEED;
    cfg_data  <= {2'b00, spd};
    @(posedge clk);
    cfg_index <= CFG_DENSITY;
    cfg_data  <= {2'b00, dens};
    @(posedge clk);
    cfg_index <= CFG_FLOOR;
    cfg_data  <= {1'b0, flr};
    @(posedge clk);
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_we    <= 1'b0;
    speed_sel = spd;
    dens_sel  = dens;
    floor_sel = flr;
    rows_sel  = rows;
    settings_loaded++;
  endtask

  task automatic seed_column(input int col);
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_cell(make_cell(REQ_SEED, col, r));
    end
    col_seeded[col] = 1'b1;
  endtask

  task automatic render_column(input int col, input bit [DT_W-1:0] dt);
    cell_req_t item;
    for (int r = 0; r < NUM_ROWS; r++) begin
      item = make_cell(REQ_RENDER, col, r);
      item.elapsed_ms = dt;
      send_cell(item);
    end
  endtask

  // stray items: ignored addresses, lone renders and lone reseeds
  task automatic send_noise();
    cell_req_t item;
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 2))
        0: begin
          if ($urandom_range(0, 1) == 0) begin
            item = make_cell(1'($urandom_range(0, 1)), $urandom_range(NUM_COLS, 31),
                             $urandom_range(0, 15));
          end else begin
            item = make_cell(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                             $urandom_range(NUM_ROWS, 15));
          end
        end
        1:       item = make_cell(REQ_RENDER, pick_seeded_column(),
                                  $urandom_range(0, NUM_ROWS - 1));
        default: item = make_cell(REQ_SEED, $urandom_range(0, NUM_COLS - 1),
                                  $urandom_range(0, NUM_ROWS - 1));
      endcase
      if (item.req_type == REQ_SEED && item.column < NUM_COLS && item.row == 0) begin
        col_seeded[item.column] = 1'b1;
      end
      send_cell(item);
    end
  endtask

  // field extremes, head, digit floor, dark cell, clamping, respawn, reseed
  task automatic test_seed_render_edges();
    cell_req_t item;
    // all-ones random words on the first column, all zeros on the last
    item = make_cell(REQ_SEED, 0, 0);
    item.rand_head   = '1;
    item.rand_trail  = '1;
    item.rand_period = '1;
    item.rand_glyph  = '1;
    send_cell(item);
    col_seeded[0] = 1'b1;
    item = make_cell(REQ_SEED, NUM_COLS - 1, 0);
    item.rand_head   = '0;
    item.rand_trail  = '0;
    item.rand_period = '0;
    item.rand_glyph  = '0;
    send_cell(item);
    col_seeded[NUM_COLS - 1] = 1'b1;
    item = make_cell(REQ_SEED, NUM_COLS - 1, NUM_ROWS - 1);
    item.rand_glyph = 32'd149;
    send_cell(item);
    send_cell(make_cell(REQ_SEED, NUM_COLS - 1, 1));

    // head cell with zero elapsed time, last glyph of the low range
    item = make_cell(REQ_RENDER, NUM_COLS - 1, 0);
    item.elapsed_ms  = 16'd0;
    item.clock_digit = 1'b0;
    item.rand_glyph  = 32'd93;
    send_cell(item);

    // digit cell lifted to the floor twice, the second keeps its glyph
    repeat (2) begin
      item = make_cell(REQ_RENDER, NUM_COLS - 1, 1);
      item.clock_digit = 1'b1;
      send_cell(item);
    end

    // dark cell
    item = make_cell(REQ_RENDER, NUM_COLS - 1, NUM_ROWS - 1);
    item.clock_digit = 1'b0;
    send_cell(item);

    // elapsed time above the clamp
    item = make_cell(REQ_RENDER, 0, 0);
    item.elapsed_ms = 16'hFFFF;
    send_cell(item);
    item = make_cell(REQ_RENDER, 0, 0);
    item.elapsed_ms  = 16'd101;
    item.clock_digit = 1'b1;
    send_cell(item);

    // run the last column past the bottom until it respawns on the first glyph
    // of the high range
    repeat (4) begin
      item = make_cell(REQ_RENDER, NUM_COLS - 1, 0);
      item.elapsed_ms = 16'd100;
      item.rand_head  = '0;
      item.rand_glyph = 32'd94;
      send_cell(item);
    end

    // reseed clears the remembered alpha
    send_cell(make_cell(REQ_SEED, NUM_COLS - 1, 1));
    item = make_cell(REQ_RENDER, NUM_COLS - 1, 1);
    item.clock_digit = 1'b1;
    send_cell(item);
    wait_idle();
  endtask

  // addresses outside the grid leave everything alone
  task automatic test_address_range();
    send_cell(make_cell(REQ_SEED, NUM_COLS, 0));
    send_cell(make_cell(REQ_RENDER, 31, 15));
    send_cell(make_cell(REQ_SEED, 0, NUM_ROWS));
    send_cell(make_cell(REQ_RENDER, NUM_COLS - 1, 15));
    send_cell(make_cell(REQ_SEED, 31, 0));
    send_cell(make_cell(REQ_RENDER, 0, 0));
    wait_idle();
  endtask

  // register settings in turn, each with seeded columns and rendered frames
  task automatic test_rain_phases();
    int target;
    int phase;
    bit [DT_W-1:0] dt;
    target = accepted_cells + RANDOM_ITEMS;
    phase  = 0;
    while (accepted_cells < target) begin
      case (phase)
        0:       load_config(2'd3, 2'd3, 3'd4, 4'd0);
        1:       load_config(2'd0, 2'd1, 3'd7, 4'd15);
        2:       load_config(2'd2, 2'd2, 3'd5, 4'd13);
        3:       load_config(2'd1, 2'd0, 3'd3, 4'd1);
        default: load_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                             3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      endcase
      repeat ($urandom_range(2, 4)) seed_column($urandom_range(0, NUM_COLS - 1));
      repeat ($urandom_range(4, 10)) begin
        dt = pick_elapsed();
        repeat ($urandom_range(1, 4)) render_column(pick_seeded_column(), dt);
        if ($urandom_range(0, 3) == 0) send_noise();
      end
      wait_idle();
      phase++;
    end
  endtask

  // result check and receiver stall pattern
  always @(posedge clk) begin : result_check
    cell_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        results_seen++;
        if (expected_cells.size() == 0) begin
          report_mismatch("unexpected result", 32'd1, 32'd0);
        end else begin
          want = expected_cells.pop_front();
          if (out_ch.draw !== want.draw)
            report_mismatch("draw", 32'(out_ch.draw), 32'(want.draw));
          if (out_ch.alpha !== want.alpha)
            report_mismatch("alpha", 32'(out_ch.alpha), 32'(want.alpha));
          if (out_ch.glyph_index !== want.glyph_index)
            report_mismatch("glyph_index", 32'(out_ch.glyph_index),
                            32'(want.glyph_index));
          if (out_ch.code_point !== want.code_point)
            report_mismatch("code_point", 32'(out_ch.code_point),
                            32'(want.code_point));
          if (out_ch.color !== want.color)
            report_mismatch("color", 32'(out_ch.color), 32'(want.color));
        end
      end
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_open_left > 0) begin
        rx_open_left--;
        out_ch.ready <= 1'b1;
      end else begin
        rx_open_left  = $urandom_range(1, 30);
        rx_stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin
    int spins;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_SPEED;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_SEED;
    in_ch.column      <= '0;
    in_ch.row         <= '0;
    in_ch.elapsed_ms  <= '0;
    in_ch.rand_head   <= '0;
    in_ch.rand_trail  <= '0;
    in_ch.rand_period <= '0;
    in_ch.rand_glyph  <= '0;
    in_ch.clock_digit <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_seed_render_edges();
    test_address_range();
    test_rain_phases();

    // let the last results drain, bounded
    in_ch.valid <= 1'b0;
    spins = 0;
    while (expected_cells.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_cells.size() != 0) begin
      report_mismatch("results never delivered", 32'(expected_cells.size()), 32'd0);
    end

    $display("run covered %0d input transfers (%0d in the grid), %0d results, %0d drawn",
             transfers_in, accepted_cells, results_seen, drawn_cells);
    $display("over %0d register settings with %0d column respawns, %0d mismatches",
             settings_loaded, respawns, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
